@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files of the range minimum segment tree.
// The macros expect clk_i and rst_ni to be visible where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define RMST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// The condition must never be true outside reset.
`define RMST_NEVER(lbl, cond, msg) \
  `RMST_ASSERT(lbl, !(cond), msg)

`endif

@@ rtl/rmst_pkg.sv @@
// Package of the range minimum segment tree: field widths, command codes,
// the empty marker and the input saturation function. No dependencies.
package rmst_pkg;

  localparam int CMD_W   = 2;
  localparam int IDX_W   = 10;
  localparam int VAL_W   = 62;
  localparam int CNT_W   = 11;
  localparam int FOUND_W = 11;

  localparam int LEAVES_DEF = 1024;
  localparam int CNT_RESET  = 1024;

  // 2^60 marks a node with no value; -2^60 is the lowest legal value.
  localparam logic signed [VAL_W-1:0] EMPTY_MARK = 62'sh1000000000000000;
  localparam logic signed [VAL_W-1:0] EMPTY_NEG  = 62'sh3000000000000000;

  typedef enum logic [CMD_W-1:0] {
    CMD_UPDATE = 2'd0,
    CMD_READ   = 2'd1,
    CMD_FIND   = 2'd2
  } cmd_e;

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [VAL_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    r = v;
    if (v > EMPTY_MARK) begin
      r = EMPTY_MARK;
    end else if (v < EMPTY_NEG) begin
      r = EMPTY_NEG;
    end
    return r;
  endfunction

endpackage

@@ rtl/rmst_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; used for the node store of the range minimum segment tree.
module rmst_ram #(
  parameter int WIDTH = 62,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/range_min_segment_tree.sv @@
// Channel  | Direction | Handshake                  | Payload
// input    | in        | in_valid_i / in_stall_o    | cmd, start_index, end_index, operand_value
// result   | out       | out_valid_o / out_stall_i  | min_value, found_index
// config   | in        | cfg_valid_i / cfg_ready_o  | element_count
//
// After reset a clearing pass writes the empty marker to all 2*LEAVES nodes, one per cycle;
// in_stall_o stays high during it.
// One comparator and a single-port-read node RAM do all the work, so node reads are done one
// at a time: update climbs from the leaf to the root, range read walks the tree level by level,
// and find works per tree level in three phases (climb, stacked right-side nodes, descent).
// A finished transaction waits in the output register; a new item is taken meanwhile, but its
// result is held back until the previous one has been taken.
// Depends on rmst_pkg, rmst_ram and assert_macros.svh.
`include "assert_macros.svh"

module range_min_segment_tree import rmst_pkg::*; #(
  parameter int LEAVES = LEAVES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [CMD_W-1:0]          cmd_i,
  input  logic [IDX_W-1:0]          start_index_i,
  input  logic [IDX_W-1:0]          end_index_i,
  input  logic signed [VAL_W-1:0]   operand_value_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [VAL_W-1:0]   min_value_o,
  output logic signed [FOUND_W-1:0] found_index_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CNT_W-1:0]          cfg_element_count_i
);

  localparam int AW  = $clog2(2 * LEAVES);
  localparam int NW  = AW + 1;
  localparam int CW  = (NW > CNT_W) ? NW : CNT_W;
  localparam int SD  = AW;
  localparam int SPW = $clog2(SD + 1);
  localparam int SIW = $clog2(SD);
  localparam int LAST_RST = ((CNT_RESET < LEAVES) ? CNT_RESET : LEAVES) - 1;

  localparam logic [CW-1:0] L_C      = CW'(LEAVES);
  localparam logic [CW-1:0] L_M1     = CW'(LEAVES - 1);
  localparam logic [AW-1:0] L_A      = AW'(LEAVES);
  localparam logic [AW-1:0] CLR_LAST = AW'(2 * LEAVES - 1);

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_U_LEAF = 4'd2;
  localparam logic [3:0] ST_U_SIB  = 4'd3;
  localparam logic [3:0] ST_C_TOP  = 4'd4;
  localparam logic [3:0] ST_C_S    = 4'd5;
  localparam logic [3:0] ST_C_E    = 4'd6;
  localparam logic [3:0] ST_POP    = 4'd7;
  localparam logic [3:0] ST_POP_W  = 4'd8;
  localparam logic [3:0] ST_DESC   = 4'd9;
  localparam logic [3:0] ST_FINISH = 4'd10;

  logic [3:0]               state_q, state_d;
  logic [AW-1:0]            clr_q, clr_d;
  logic [NW-1:0]            s_q, s_d, e_q, e_d;
  logic [NW-1:0]            first_q, first_d;
  logic [AW-1:0]            k_q, k_d;
  logic [SPW-1:0]           sp_q, sp_d;
  logic [AW-1:0]            stk_q [SD];
  logic signed [VAL_W-1:0]  acc_q, acc_d, val_q, val_d;
  logic                     find_q, find_d;
  logic [CW-1:0]            last_q, last_d;
  logic signed [VAL_W-1:0]  res_min_q, res_min_d;
  logic [FOUND_W-1:0]       res_found_q, res_found_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [VAL_W-1:0]  out_min_q, out_min_d;
  logic [FOUND_W-1:0]       out_found_q, out_found_d;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic signed [VAL_W-1:0]  ram_wdata, ram_rdata;

  cmd_e                     cmd_w;
  logic signed [VAL_W-1:0]  sat_w, cmp_ref, node_min;
  logic                     node_lt;
  logic [CW-1:0]            start_w, end_w, end_cl, cfg_w, cfg_cnt0, cfg_cnt, cfg_last;
  logic [NW-1:0]            s_init, e_init_r, e_init_f, s_inc;
  logic [AW-1:0]            ent_t, nk, leaf_node, stk_top;
  logic                     ent_leaf;
  logic [CW-1:0]            leaf_sum;
  logic [FOUND_W-1:0]       found_w;
  logic [SPW-1:0]           sp_m1;
  logic                     push;
  logic                     in_fire;

  rmst_ram #(
    .WIDTH(VAL_W),
    .DEPTH(2 * LEAVES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // The shared comparator: node against the running minimum, or against the threshold.
  assign cmp_ref  = find_q ? val_q : acc_q;
  assign node_lt  = ram_rdata < cmp_ref;
  assign node_min = node_lt ? ram_rdata : cmp_ref;

  assign cmd_w    = cmd_e'(cmd_i);
  assign sat_w    = sat_val(operand_value_i);
  assign start_w  = CW'(start_index_i);
  assign end_w    = CW'(end_index_i);
  assign end_cl   = (end_w > L_M1) ? L_M1 : end_w;
  assign s_init   = NW'(start_w + L_C);
  assign e_init_r = NW'(end_cl + L_C);
  assign e_init_f = NW'(last_q + L_C);
  assign s_inc    = s_q + NW'(1);

  // Element count clamped to 1..LEAVES, stored as the last searchable index.
  assign cfg_w    = CW'(cfg_element_count_i);
  assign cfg_cnt0 = (cfg_w == '0) ? CW'(1) : cfg_w;
  assign cfg_cnt  = (cfg_cnt0 > L_C) ? L_C : cfg_cnt0;
  assign cfg_last = cfg_cnt - CW'(1);

  assign ent_t     = (state_q == ST_POP_W) ? k_q : s_q[AW-1:0];
  assign ent_leaf  = ent_t >= L_A;
  assign nk        = {k_q[AW-2:0], ~node_lt};
  assign leaf_node = (state_q == ST_DESC) ? nk : ent_t;
  // The failing leaf is one past the farthest qualifying index.
  assign leaf_sum  = CW'(leaf_node) - L_C - CW'(1);
  // When the start leaf itself fails, no index qualifies.
  assign found_w   = ({1'b0, leaf_node} == first_q) ? '1 : leaf_sum[FOUND_W-1:0];

  assign sp_m1   = sp_q - SPW'(1);
  assign stk_top = stk_q[sp_m1[SIW-1:0]];

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    s_d         = s_q;
    e_d         = e_q;
    first_d     = first_q;
    k_d         = k_q;
    sp_d        = sp_q;
    acc_d       = acc_q;
    val_d       = val_q;
    find_d      = find_q;
    last_d      = last_q;
    res_min_d   = res_min_q;
    res_found_d = res_found_q;
    out_valid_d = out_valid_q;
    out_min_d   = out_min_q;
    out_found_d = out_found_q;
    ram_we      = 1'b0;
    ram_waddr   = s_q[AW-1:0];
    ram_wdata   = acc_q;
    ram_raddr   = s_q[AW-1:0];
    push        = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = EMPTY_MARK;
        clr_d     = clr_q + AW'(1);
        if (clr_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          res_min_d   = '0;
          res_found_d = '1;
          val_d       = sat_w;
          acc_d       = sat_w;
          find_d      = 1'b0;
          sp_d        = '0;
          first_d     = s_init;
          case (cmd_w)
            CMD_UPDATE: begin
              if (start_w < L_C) begin
                s_d     = s_init;
                state_d = ST_U_LEAF;
              end else begin
                state_d = ST_FINISH;
              end
            end
            CMD_READ: begin
              acc_d = EMPTY_MARK;
              if (start_w > end_cl) begin
                res_min_d = EMPTY_MARK;
                state_d   = ST_FINISH;
              end else begin
                s_d     = s_init;
                e_d     = e_init_r;
                state_d = ST_C_TOP;
              end
            end
            CMD_FIND: begin
              find_d = 1'b1;
              if (start_w > last_q) begin
                state_d = ST_FINISH;
              end else begin
                s_d     = s_init;
                e_d     = e_init_f;
                state_d = ST_C_TOP;
              end
            end
            default: begin
              state_d = ST_FINISH;
            end
          endcase
        end
      end
      ST_U_LEAF: begin
        ram_we    = 1'b1;
        ram_waddr = s_q[AW-1:0];
        ram_wdata = acc_q;
        ram_raddr = s_q[AW-1:0] ^ AW'(1);
        state_d   = ST_U_SIB;
      end
      ST_U_SIB: begin
        // The sibling is on the read port; write the parent and fetch its sibling.
        ram_we    = 1'b1;
        ram_waddr = s_q[AW:1];
        ram_wdata = node_min;
        acc_d     = node_min;
        s_d       = s_q >> 1;
        ram_raddr = s_q[AW:1] ^ AW'(1);
        if (s_q[AW:1] == AW'(1)) begin
          state_d = ST_FINISH;
        end
      end
      ST_C_TOP: begin
        if (s_q > e_q) begin
          if (find_q) begin
            state_d = ST_POP;
          end else begin
            res_min_d = acc_q;
            state_d   = ST_FINISH;
          end
        end else if (s_q[0]) begin
          ram_raddr = s_q[AW-1:0];
          state_d   = ST_C_S;
        end else if (!e_q[0]) begin
          if (find_q) begin
            push = 1'b1;
            sp_d = sp_q + SPW'(1);
            s_d  = s_q >> 1;
            e_d  = (e_q - NW'(1)) >> 1;
          end else begin
            ram_raddr = e_q[AW-1:0];
            state_d   = ST_C_E;
          end
        end else begin
          s_d = s_q >> 1;
          e_d = e_q >> 1;
        end
      end
      ST_C_S: begin
        if (find_q) begin
          if (node_lt) begin
            if (ent_leaf) begin
              res_found_d = found_w;
              state_d     = ST_FINISH;
            end else begin
              ram_raddr = {ent_t[AW-2:0], 1'b0};
              k_d       = ent_t;
              state_d   = ST_DESC;
            end
          end else begin
            // Right-side nodes are kept for later, leftmost on top of the stack.
            if (!e_q[0]) begin
              push = 1'b1;
              sp_d = sp_q + SPW'(1);
              e_d  = (e_q - NW'(1)) >> 1;
            end else begin
              e_d = e_q >> 1;
            end
            s_d     = s_inc >> 1;
            state_d = ST_C_TOP;
          end
        end else begin
          acc_d = node_min;
          if (!e_q[0]) begin
            ram_raddr = e_q[AW-1:0];
            s_d       = s_inc;
            state_d   = ST_C_E;
          end else begin
            s_d     = s_inc >> 1;
            e_d     = e_q >> 1;
            state_d = ST_C_TOP;
          end
        end
      end
      ST_C_E: begin
        acc_d   = node_min;
        s_d     = s_q >> 1;
        e_d     = (e_q - NW'(1)) >> 1;
        state_d = ST_C_TOP;
      end
      ST_POP: begin
        if (sp_q == '0) begin
          res_found_d = last_q[FOUND_W-1:0];
          state_d     = ST_FINISH;
        end else begin
          ram_raddr = stk_top;
          k_d       = stk_top;
          sp_d      = sp_m1;
          state_d   = ST_POP_W;
        end
      end
      ST_POP_W: begin
        if (node_lt) begin
          if (ent_leaf) begin
            res_found_d = found_w;
            state_d     = ST_FINISH;
          end else begin
            ram_raddr = {ent_t[AW-2:0], 1'b0};
            k_d       = ent_t;
            state_d   = ST_DESC;
          end
        end else begin
          state_d = ST_POP;
        end
      end
      ST_DESC: begin
        // Go left when the left child already drops below the threshold.
        if (nk >= L_A) begin
          res_found_d = found_w;
          state_d     = ST_FINISH;
        end else begin
          ram_raddr = {nk[AW-2:0], 1'b0};
          k_d       = nk;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_min_d   = res_min_q;
          out_found_d = res_found_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_valid_i) begin
      last_d = cfg_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      sp_q        <= '0;
      find_q      <= 1'b0;
      last_q      <= CW'(LAST_RST);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      sp_q        <= sp_d;
      find_q      <= find_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q         <= s_d;
    e_q         <= e_d;
    first_q     <= first_d;
    k_q         <= k_d;
    acc_q       <= acc_d;
    val_q       <= val_d;
    res_min_q   <= res_min_d;
    res_found_q <= res_found_d;
    out_min_q   <= out_min_d;
    out_found_q <= out_found_d;
    if (push) begin
      stk_q[sp_q[SIW-1:0]] <= e_q[AW-1:0];
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign in_fire       = in_valid_i && !in_stall_o;
  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign min_value_o   = out_min_q;
  assign found_index_o = out_found_q;

  `RMST_ASSERT(a_accept_starts_work, in_fire |=> (state_q != ST_IDLE), "work did not start")
  `RMST_ASSERT(a_out_src, $rose(out_valid_q) |-> $past(state_q == ST_FINISH), "stray result")
  `RMST_NEVER(a_stack_bound, sp_q > SPW'(SD), "node stack overflowed")
  `RMST_ASSERT(a_desc_inner, (state_q == ST_DESC) |-> (k_q < L_A), "descent past the leaves")

endmodule
